>>> rtl/mmed_pkg.sv
// Shared types, format codes and the order-key function of the min/max envelope decimator.
// No dependencies; imported by every module of the block.
package mmed_pkg;

	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd1;

	localparam logic [3:0] FMT_I8     = 4'd0;
	localparam logic [3:0] FMT_U8     = 4'd1;
	localparam logic [3:0] FMT_I16    = 4'd2;
	localparam logic [3:0] FMT_U16    = 4'd3;
	localparam logic [3:0] FMT_I32    = 4'd4;
	localparam logic [3:0] FMT_U32    = 4'd5;
	localparam logic [3:0] FMT_I64    = 4'd6;
	localparam logic [3:0] FMT_U64    = 4'd7;
	localparam logic [3:0] FMT_BE_I16 = 4'd8;
	localparam logic [3:0] FMT_BE_U16 = 4'd9;
	localparam logic [3:0] FMT_BE_I32 = 4'd10;
	localparam logic [3:0] FMT_BE_U32 = 4'd11;
	localparam logic [3:0] FMT_F32    = 4'd12;
	localparam logic [3:0] FMT_F64    = 4'd13;

	localparam logic [31:0] SWAP_MID_HI = 32'h00ff0000;
	localparam logic [31:0] SWAP_MID_LO = 32'h0000ff00;

	typedef struct packed {
		logic [63:0] raw_word;
		logic        bucket_end;
	} mmed_in_t;

	typedef struct packed {
		logic [2:0]  channel_index;
		logic [63:0] minimum;
		logic [63:0] maximum;
		logic        empty_res;
		logic        last;
	} mmed_out_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] value;
		logic [63:0] key;
	} mmed_dec_t;

	// Unsigned key whose order is the native order of the format.
	function automatic logic [63:0] order_key(input logic [3:0] fmt, input logic [63:0] v);
		logic [63:0] k;
		k = v;
		case (fmt)
			FMT_I8, FMT_I16, FMT_I32, FMT_I64, FMT_BE_I16, FMT_BE_I32: begin
				k = v ^ 64'h8000_0000_0000_0000;
			end
			FMT_F32: begin
				if (v[30:0] == 31'd0) k = 64'h0000_0000_8000_0000;
				else if (v[31]) k = {32'd0, ~v[31:0]};
				else k = {32'd0, 1'b1, v[30:0]};
			end
			FMT_F64: begin
				if (v[62:0] == 63'd0) k = 64'h8000_0000_0000_0000;
				else if (v[63]) k = ~v;
				else k = {1'b1, v[62:0]};
			end
			default: k = v;
		endcase
		return k;
	endfunction

endpackage

>>> rtl/mmed_sample_decode.sv
// Sample word decoder: format decode, NaN / bad-format rejection and order key.
// Depends on mmed_pkg.
module mmed_sample_decode import mmed_pkg::*; (
	input  logic [3:0]  fmt,
	input  logic [63:0] raw,
	output mmed_dec_t   dec
);

	logic [15:0] sw16;
	logic [31:0] sw32;
	logic [31:0] w32;

	assign w32  = raw[31:0];
	assign sw16 = {raw[7:0], raw[15:8]};
	assign sw32 = ((w32 << 24) & 32'hff000000) | (w32 >> 24) |
		((w32 << 8) & SWAP_MID_HI) | ((w32 >> 8) & SWAP_MID_LO);

	always_comb begin
		dec.valid = 1'b1;
		dec.value = raw;
		case (fmt)
			FMT_I8:     dec.value = {{56{raw[7]}}, raw[7:0]};
			FMT_U8:     dec.value = {56'd0, raw[7:0]};
			FMT_I16:    dec.value = {{48{raw[15]}}, raw[15:0]};
			FMT_U16:    dec.value = {48'd0, raw[15:0]};
			FMT_I32:    dec.value = {{32{raw[31]}}, raw[31:0]};
			FMT_U32:    dec.value = {32'd0, raw[31:0]};
			FMT_I64, FMT_U64: dec.value = raw;
			FMT_BE_I16: dec.value = {{48{sw16[15]}}, sw16};
			FMT_BE_U16: dec.value = {48'd0, sw16};
			FMT_BE_I32: dec.value = {{32{sw32[31]}}, sw32};
			FMT_BE_U32: dec.value = {32'd0, sw32};
			FMT_F32: begin
				dec.value = {32'd0, w32};
				// exponent all ones with a nonzero fraction: NaN
				if (w32[30:23] == 8'hff && w32[22:0] != 23'd0) dec.valid = 1'b0;
			end
			FMT_F64: begin
				dec.value = raw;
				if (raw[62:52] == 11'h7ff && raw[51:0] != 52'd0) dec.valid = 1'b0;
			end
			default: dec.valid = 1'b0;
		endcase
		dec.key = order_key(fmt, dec.value);
	end

endmodule

>>> rtl/min_max_envelope_decimator_core.sv
// Top level of the min/max envelope decimator: input stage, per-channel envelope store,
// report bank and result channel. Depends on mmed_pkg and mmed_sample_decode.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one interleaved channel sample per
//   transfer; channels rotate 0..channel_count-1 and wrap. A transfer with bucket_end set
//   closes the bucket: the envelope of every configured channel is reported, channel 0
//   first, on the output channel (out_valid/out_ready/out_data), one transfer per cycle,
//   with last set on the final channel. The store then starts a fresh bucket.
//   Throughput: one input transfer per cycle but for the stall below. The input stage is one
//   register deep and the store is updated from it; a bucket's first report is offered once
//   its bucket_end leaves that stage and loads the bank; reports follow at one per cycle.
//   Reports come from a separate bank, so samples of the next bucket keep flowing while a
//   report drains. A second bucket_end waits in the input stage only while the bank is
//   still being drained; that is the only stall, and it is set by the out_ready pace.
//   If the receiver stalls, out_data holds and the bank waits.
//   Reset: sample_format int8, channel_count 1, channel position 0, store and bank empty.
//   Configuration writes (cfg_we/cfg_index/cfg_data) take effect at the next edge; the user
//   must make them only while the block is idle, which the block itself does not enforce.
module min_max_envelope_decimator_core import mmed_pkg::*; #(
	parameter int unsigned MAX_CHANNELS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  mmed_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output mmed_out_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_CHANNELS + 1);

	// configuration
	logic [3:0] fmt_q;
	logic [3:0] count_q;
	logic [CNT_W-1:0] eff_n;

	// input stage
	logic            in_xfer;
	logic [CH_W-1:0] pos_q;
	logic [CH_W-1:0] in_ch;
	logic [CH_W-1:0] pos_next;
	logic            s1_valid_q;
	logic [63:0]     raw_s1;
	logic            be_s1;
	logic [CH_W-1:0] ch_s1;
	logic            s1_go;

	// live store
	logic [63:0] min_q  [MAX_CHANNELS];
	logic [63:0] max_q  [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0] seen_q;
	logic [63:0] upd_min [MAX_CHANNELS];
	logic [63:0] upd_max [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0] upd_seen;

	// report bank
	logic [63:0] bmin_q [MAX_CHANNELS];
	logic [63:0] bmax_q [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0] bseen_q;
	logic             busy_q;
	logic [CNT_W-1:0] bank_n_q;
	logic [CH_W-1:0]  emit_q;
	logic             emit_last;
	logic             out_xfer;

	mmed_dec_t   dec;
	logic [63:0] cur_min;
	logic [63:0] cur_max;
	logic        cur_seen;
	logic        take_min;
	logic        take_max;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= FMT_I8;
			count_q <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLE_FORMAT: fmt_q   <= cfg_data;
				REG_CHANNEL_COUNT: count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// count 0 acts as 1, counts above the store depth are clamped
	always_comb begin
		if (count_q == 4'd0) eff_n = CNT_W'(1);
		else if (int'(count_q) > int'(MAX_CHANNELS)) eff_n = CNT_W'(MAX_CHANNELS);
		else eff_n = CNT_W'(count_q);
	end

	// ---------------- input stage ----------------
	// a bucket end may only leave s1 once the bank is free
	assign s1_go    = !(be_s1 && busy_q);
	assign in_ready = !s1_valid_q || s1_go;
	assign in_xfer  = in_valid && in_ready;

	// position past the count (after a count change) falls back to channel 0
	assign in_ch    = (CNT_W'(pos_q) < eff_n) ? pos_q : '0;
	assign pos_next = (CNT_W'(CNT_W'(in_ch) + CNT_W'(1)) < eff_n) ?
		CH_W'(CNT_W'(in_ch) + CNT_W'(1)) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			s1_valid_q <= 1'b0;
			be_s1      <= 1'b0;
		end else begin
			if (in_xfer) begin
				pos_q      <= in_data.bucket_end ? '0 : pos_next;
				s1_valid_q <= 1'b1;
				be_s1      <= in_data.bucket_end;
			end else if (s1_go) begin
				s1_valid_q <= 1'b0;
				be_s1      <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			raw_s1 <= in_data.raw_word;
			ch_s1  <= in_ch;
		end
	end

	// ---------------- decode and compare ----------------
	mmed_sample_decode u_decode (
		.fmt (fmt_q),
		.raw (raw_s1),
		.dec (dec)
	);

	assign cur_min  = min_q[ch_s1];
	assign cur_max  = max_q[ch_s1];
	assign cur_seen = seen_q[ch_s1];
	// strict compares: ties keep the stored value, so -0 vs +0 keeps the first
	assign take_min = !cur_seen || (dec.key < order_key(fmt_q, cur_min));
	assign take_max = !cur_seen || (dec.key > order_key(fmt_q, cur_max));

	always_comb begin
		for (int c = 0; c < MAX_CHANNELS; c++) begin
			upd_min[c]  = min_q[c];
			upd_max[c]  = max_q[c];
			upd_seen[c] = seen_q[c];
		end
		if (s1_valid_q && dec.valid) begin
			if (take_min) upd_min[ch_s1] = dec.value;
			if (take_max) upd_max[ch_s1] = dec.value;
			upd_seen[ch_s1] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (s1_valid_q && s1_go) begin
			seen_q <= be_s1 ? '0 : upd_seen;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && s1_go) begin
			for (int c = 0; c < MAX_CHANNELS; c++) begin
				min_q[c] <= upd_min[c];
				max_q[c] <= upd_max[c];
			end
		end
	end

	// ---------------- report bank ----------------
	assign out_xfer  = out_valid && out_ready;
	assign emit_last = (CNT_W'(CNT_W'(emit_q) + CNT_W'(1)) == bank_n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			emit_q   <= '0;
			bank_n_q <= CNT_W'(1);
			bseen_q  <= '0;
		end else begin
			if (s1_valid_q && be_s1 && s1_go) begin
				busy_q   <= 1'b1;
				emit_q   <= '0;
				bank_n_q <= eff_n;
				bseen_q  <= upd_seen;
			end else if (out_xfer) begin
				if (emit_last) busy_q <= 1'b0;
				else emit_q <= CH_W'(CNT_W'(emit_q) + CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && be_s1 && s1_go) begin
			for (int c = 0; c < MAX_CHANNELS; c++) begin
				bmin_q[c] <= upd_min[c];
				bmax_q[c] <= upd_max[c];
			end
		end
	end

	// empty channels report zero envelopes
	assign out_valid              = busy_q;
	assign out_data.channel_index = 3'(emit_q);
	assign out_data.minimum       = bseen_q[emit_q] ? bmin_q[emit_q] : 64'd0;
	assign out_data.maximum       = bseen_q[emit_q] ? bmax_q[emit_q] : 64'd0;
	assign out_data.empty_res     = !bseen_q[emit_q];
	assign out_data.last          = emit_last;

	// ---------------- assertions ----------------
	a_last_ends_report: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && out_data.last) |=> !out_valid)
		else $error("report continued after last");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (CNT_W'(emit_q) < bank_n_q))
		else $error("report index beyond bank count");

	a_channel_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && !out_data.last) |=>
		(out_valid && emit_q == CH_W'(CNT_W'($past(emit_q)) + CNT_W'(1))))
		else $error("report channel did not advance by one");

	a_s1_channel_range: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> (CNT_W'(ch_s1) < eff_n))
		else $error("input stage holds a channel beyond the count");

endmodule
